// File: hdl/twpb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twpb_pkg: shared types and constants for the tiered weight placement block
// Region table geometry, tier and operation codes, sequencer states, table entry and resident size.
// ----------------------------------------------------------------------------
package twpb_pkg;

   localparam int MaxRegions = 8192;
   localparam int IdxW       = $clog2(MaxRegions);
   localparam int CntW       = IdxW + 1;
   localparam int SizeW      = 40;
   localparam int BytesW     = 52;
   localparam int TierW      = 3;
   localparam int LoadsW     = 32;
   localparam int EntryW     = SizeW + TierW + 1 + LoadsW;

   localparam logic [TierW-1:0] TIER_Q4  = 3'd2;
   localparam logic [TierW-1:0] TIER_Q2  = 3'd3;
   localparam logic [TierW-1:0] TIER_SSD = 3'd4;

   localparam logic [2:0] OP_REGISTER = 3'd0;
   localparam logic [2:0] OP_TIER     = 3'd1;
   localparam logic [2:0] OP_ACCESS   = 3'd2;
   localparam logic [2:0] OP_EVICT    = 3'd3;
   localparam logic [2:0] OP_COLD     = 3'd4;
   localparam logic [2:0] OP_TRIM     = 3'd5;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_EXEC,
      ST_CHECK,
      ST_COLD_RD,
      ST_COLD_WAIT,
      ST_COLD_EX,
      ST_RECHECK,
      ST_FINAL_RD,
      ST_FINAL_WAIT,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [SizeW-1:0]  size;
      logic [TierW-1:0]  tier;
      logic              loaded;
      logic [LoadsW-1:0] loads;
   } entry_type;

   function automatic logic [BytesW-1:0] resident(input logic [SizeW-1:0] sz,
                                                  input logic [TierW-1:0] t);
      logic [BytesW-1:0] r;
      r = '0;
      case (t)
         3'd0:    r = BytesW'(sz >> 1);
         3'd1:    r = BytesW'(sz >> 2);
         3'd2:    r = BytesW'(sz >> 3);
         3'd3:    r = BytesW'(sz >> 4);
         default: r = BytesW'(sz >> 5);
      endcase
      return r;
   endfunction

endpackage

// File: hdl/twpb_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twpb_table: region table memory
// One write port, one registered read port.
// ----------------------------------------------------------------------------
module twpb_table import twpb_pkg::*; (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IdxW-1:0]  wr_addr,
   input  entry_type        wr_data,
   input  logic [IdxW-1:0]  rd_addr,
   output entry_type        rd_data
);

   entry_type mem [MaxRegions];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/tiered_weight_placement_budget.sv
`timescale 1ns / 1ps
// Register, access, evict and a tier change within RAM or to SSD read the region,
// execute and read the result; a tier change from SSD to RAM adds a budget check,
// a cold sweep if over budget, and a recheck; rejected items and trim under budget
// answer after the read. Cold evict and over-budget trim sweep all registered regions.
// One item at a time; input is ready again in the cycle after the result is taken.
// Reset clears region count, used total and budget; the table is never read unwritten.
// ----------------------------------------------------------------------------
// tiered_weight_placement_budget: region placement with a RAM byte budget
// Sequencer over one region table and one shared 52-bit add/compare unit.
// ----------------------------------------------------------------------------
module tiered_weight_placement_budget import twpb_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_wr_en,
   input  logic [51:0]   csr_wr_data,
   input  logic          req_tvalid,
   output logic          req_tready,
   // kind[2:0], region_index[15:3], region_size[55:16], tier[58:56]
   input  logic [63:0]   req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // status[0], result_index[13:1], result_tier[16:14], result_loaded[17],
   // result_loads[49:18], used_bytes[101:50], avail_bytes[153:102],
   // evicted_count[167:154]
   output logic [167:0]  rsp_tdata
);

   state_type state_ff, state_in;
   logic [BytesW-1:0] budget_ff;
   logic [BytesW-1:0] used_ff, used_in;
   logic [CntW-1:0]   count_ff, count_in;
   logic [2:0]        kind_ff, kind_in;
   logic [IdxW-1:0]   idx_ff, idx_in;
   logic [SizeW-1:0]  rsize_ff, rsize_in;
   logic [TierW-1:0]  tier_ff, tier_in;
   logic [CntW-1:0]   scan_ff, scan_in;
   logic [CntW-1:0]   evicted_ff, evicted_in;
   logic              status_ff, status_in;
   logic              report_ff, report_in;
   logic [IdxW-1:0]   rindex_ff, rindex_in;
   logic [BytesW-1:0] freed_ff, freed_in;
   logic [BytesW-1:0] nb_ff, nb_in;
   entry_type         final_ff, final_in;
   // record of a region leaving SSD, held across the cold sweep
   entry_type         hold_ff, hold_in;

   logic              wr_en;
   logic [IdxW-1:0]   wr_addr, rd_addr;
   entry_type         wr_data, rd_data;

   // shared arithmetic unit: a + b - c, compare against budget
   logic [BytesW-1:0] alu_a, alu_b, alu_c;
   logic [BytesW+1:0] alu_sum;
   logic              alu_over;
   assign alu_sum  = {2'b0, alu_a} + {2'b0, alu_b} - {2'b0, alu_c};
   assign alu_over = alu_sum > {2'b0, budget_ff};

   twpb_table u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   logic [TierW-1:0]  req_tier_c;
   logic [BytesW-1:0] rd_res, sub_res;
   logic [LoadsW-1:0] bumped, hold_bumped;
   assign req_tier_c = (req_tdata[58:56] > TIER_SSD) ? TIER_SSD : req_tdata[58:56];
   assign rd_res = resident(rd_data.size, rd_data.tier);
   assign bumped = (&rd_data.loads) ? rd_data.loads : rd_data.loads + 1'b1;
   assign hold_bumped = (&hold_ff.loads) ? hold_ff.loads : hold_ff.loads + 1'b1;
   always_comb begin
      sub_res = (used_ff >= rd_res) ? used_ff - rd_res : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         budget_ff <= '0;
         used_ff   <= '0;
         count_ff  <= '0;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
         count_ff <= count_in;
         if (csr_wr_en) begin
            budget_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      idx_ff     <= idx_in;
      rsize_ff   <= rsize_in;
      tier_ff    <= tier_in;
      scan_ff    <= scan_in;
      evicted_ff <= evicted_in;
      status_ff  <= status_in;
      report_ff  <= report_in;
      rindex_ff  <= rindex_in;
      freed_ff   <= freed_in;
      nb_ff      <= nb_in;
      final_ff   <= final_in;
      hold_ff    <= hold_in;
   end

   always_comb begin
      state_in   = state_ff;
      used_in    = used_ff;
      count_in   = count_ff;
      kind_in    = kind_ff;
      idx_in     = idx_ff;
      rsize_in   = rsize_ff;
      tier_in    = tier_ff;
      scan_in    = scan_ff;
      evicted_in = evicted_ff;
      status_in  = status_ff;
      report_in  = report_ff;
      rindex_in  = rindex_ff;
      freed_in   = freed_ff;
      nb_in      = nb_ff;
      final_in   = final_ff;
      hold_in    = hold_ff;
      wr_en      = 1'b0;
      wr_addr    = idx_ff;
      wr_data    = rd_data;
      rd_addr    = idx_ff;
      alu_a      = used_ff;
      alu_b      = nb_ff;
      alu_c      = freed_ff;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               kind_in    = req_tdata[2:0];
               idx_in     = req_tdata[15:3];
               rsize_in   = req_tdata[55:16];
               tier_in    = req_tier_c;
               evicted_in = '0;
               status_in  = 1'b1;
               report_in  = 1'b0;
               rindex_in  = '0;
               scan_in    = '0;
               final_in   = '0;
               state_in   = ST_READ;
            end
         end
         ST_READ: begin
            // table read address settles this cycle
            unique case (kind_ff)
               OP_REGISTER: begin
                  if (count_ff < CntW'(MaxRegions)) begin
                     idx_in   = count_ff[IdxW-1:0];
                     nb_in    = (tier_ff == TIER_SSD) ? '0 : resident(rsize_ff, tier_ff);
                     freed_in = '0;
                     state_in = ST_EXEC;
                  end else begin
                     state_in = ST_OUT;
                  end
               end
               OP_TIER, OP_ACCESS, OP_EVICT: begin
                  state_in = ({1'b0, idx_ff} < count_ff) ? ST_EXEC : ST_OUT;
               end
               OP_COLD: begin
                  status_in = 1'b0;
                  state_in  = ST_COLD_RD;
               end
               OP_TRIM: begin
                  status_in = 1'b0;
                  state_in  = (used_ff > budget_ff) ? ST_COLD_RD : ST_OUT;
               end
               default: state_in = ST_OUT;
            endcase
         end
         ST_EXEC: begin
            status_in = 1'b0;
            report_in = 1'b1;
            state_in  = ST_FINAL_RD;
            unique case (kind_ff)
               OP_REGISTER: begin
                  alu_c        = '0;
                  wr_en        = 1'b1;
                  wr_data.size = rsize_ff;
                  wr_data.tier = tier_ff;
                  wr_data.loaded = 1'b0;
                  wr_data.loads  = '0;
                  if (tier_ff != TIER_SSD) begin
                     if (alu_over) begin
                        wr_data.tier = TIER_SSD;
                     end else begin
                        wr_data.loaded = 1'b1;
                        wr_data.loads  = 32'd1;
                        used_in        = alu_sum[BytesW-1:0];
                     end
                  end
                  rindex_in = idx_ff;
                  count_in  = count_ff + 1'b1;
               end
               OP_TIER: begin
                  if (rd_data.tier == tier_ff) begin
                     // no change
                  end else if (rd_data.tier != TIER_SSD && tier_ff != TIER_SSD) begin
                     if (rd_data.loaded) begin
                        alu_a   = sub_res;
                        alu_b   = resident(rd_data.size, tier_ff);
                        alu_c   = '0;
                        used_in = alu_sum[BytesW-1:0];
                     end
                     wr_en        = 1'b1;
                     wr_data.tier = tier_ff;
                  end else if (rd_data.tier == TIER_SSD) begin
                     freed_in = rd_data.loaded ? rd_res : '0;
                     nb_in    = resident(rd_data.size, tier_ff);
                     hold_in  = rd_data;
                     state_in = ST_CHECK;
                  end else begin
                     if (rd_data.loaded) begin
                        used_in = sub_res;
                     end
                     wr_en          = 1'b1;
                     wr_data.loaded = 1'b0;
                     wr_data.tier   = TIER_SSD;
                  end
               end
               OP_ACCESS: begin
                  if (!rd_data.loaded) begin
                     alu_b          = rd_res;
                     alu_c          = '0;
                     used_in        = alu_sum[BytesW-1:0];
                     wr_en          = 1'b1;
                     wr_data.loaded = 1'b1;
                     wr_data.loads  = bumped;
                  end
               end
               default: begin
                  if (rd_data.loaded) begin
                     used_in = sub_res;
                  end
                  evicted_in     = CntW'(rd_data.loaded || rd_data.tier != TIER_SSD);
                  wr_en          = 1'b1;
                  wr_data.loaded = 1'b0;
                  wr_data.tier   = TIER_SSD;
               end
            endcase
         end
         ST_CHECK: begin
            state_in = alu_over ? ST_COLD_RD : ST_RECHECK;
         end
         ST_COLD_RD: begin
            rd_addr  = scan_ff[IdxW-1:0];
            state_in = (scan_ff < count_ff) ? ST_COLD_WAIT : ST_RECHECK;
         end
         ST_COLD_WAIT: begin
            rd_addr  = scan_ff[IdxW-1:0];
            state_in = ST_COLD_EX;
         end
         ST_COLD_EX: begin
            wr_addr = scan_ff[IdxW-1:0];
            if (rd_data.tier == TIER_Q4 || rd_data.tier == TIER_Q2) begin
               if (rd_data.loaded) begin
                  used_in = sub_res;
               end
               wr_en          = 1'b1;
               wr_data.loaded = 1'b0;
               wr_data.tier   = TIER_SSD;
               evicted_in     = evicted_ff + 1'b1;
            end
            scan_in  = scan_ff + 1'b1;
            state_in = ST_COLD_RD;
         end
         ST_RECHECK: begin
            if (kind_ff == OP_TIER) begin
               state_in = ST_FINAL_RD;
               if (alu_over) begin
                  status_in = 1'b1;
               end else begin
                  // used - freed + nb; freed <= used by the matched accounting
                  used_in        = alu_sum[BytesW-1:0];
                  wr_en          = 1'b1;
                  wr_data        = hold_ff;
                  wr_data.loaded = 1'b1;
                  wr_data.tier   = tier_ff;
                  wr_data.loads  = hold_bumped;
               end
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_FINAL_RD: begin
            state_in = ST_FINAL_WAIT;
         end
         ST_FINAL_WAIT: begin
            final_in = rd_data;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   logic [BytesW-1:0] avail;
   assign avail = (budget_ff > used_ff) ? budget_ff - used_ff : '0;

   assign rsp_tdata = {evicted_ff, avail, used_ff,
                       report_ff ? final_ff.loads : {LoadsW{1'b0}},
                       report_ff ? final_ff.loaded : 1'b0,
                       report_ff ? final_ff.tier : {TierW{1'b0}},
                       rindex_ff, status_ff};

endmodule

// File: tb/sv/tiered_weight_placement_budget_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tiered_weight_placement_budget_test: self-checking bench for region placement
// Drives directed and random region operations across several budgets,
// predicts each response in place and compares it whole, printing fields on a mismatch.
// ----------------------------------------------------------------------------
module tiered_weight_placement_budget_test import twpb_pkg::*; ();

   localparam int LIMIT_CYCLES = 12000000;
   localparam logic [BytesW-1:0] BUDGET_MAX = '1;

   typedef struct packed {
      logic [2:0]        kind;
      logic [IdxW-1:0]   idx;
      logic [SizeW-1:0]  size;
      logic [TierW-1:0]  tier;
   } op_type;

   // laid out as on rsp_tdata, highest field first
   typedef struct packed {
      logic [CntW-1:0]   evicted;
      logic [BytesW-1:0] avail;
      logic [BytesW-1:0] used;
      logic [LoadsW-1:0] loads;
      logic              loaded;
      logic [TierW-1:0]  tier;
      logic [IdxW-1:0]   index;
      logic              status;
   } outcome_type;

   typedef struct {
      op_type      op;
      logic        fixed;    // expected outcome given in the table
      outcome_type want;
   } plan_row_type;

   logic clock = 0;
   logic reset = 1;
   logic csr_wr_en = 0;
   logic [51:0] csr_wr_data = '0;
   logic req_tvalid = 0;
   logic req_tready;
   logic [63:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [167:0] rsp_tdata;

   tiered_weight_placement_budget DUT (.*);

   always #2 clock = ~clock;

   // shadow of the region table
   logic [BytesW-1:0] budget_sh;
   int unsigned       nregions;
   logic [BytesW-1:0] used_sh;
   logic [SizeW-1:0]  sz_sh   [MaxRegions];
   logic [TierW-1:0]  tier_sh [MaxRegions];
   logic              ld_sh   [MaxRegions];
   logic [LoadsW-1:0] cnt_sh  [MaxRegions];

   outcome_type pending_outcomes[$];
   int     errors = 0;
   int     got = 0;
   bit     calm = 0;      // no idling in the last part
   bit     hold_rsp = 0;
   int     rsp_gap = 0;

   function automatic logic [BytesW-1:0] share(logic [SizeW-1:0] s, logic [TierW-1:0] t);
      return BytesW'(s) >> (t + 1);
   endfunction

   function automatic logic [BytesW-1:0] drop(logic [BytesW-1:0] a, logic [BytesW-1:0] b);
      return a >= b ? a - b : '0;
   endfunction

   function automatic int sweep_cold();
      int n;
      n = 0;
      for (int i = 0; i < nregions; i++)
         if (tier_sh[i] == TIER_Q4 || tier_sh[i] == TIER_Q2) begin
            if (ld_sh[i]) used_sh = drop(used_sh, share(sz_sh[i], tier_sh[i]));
            ld_sh[i] = 0;
            tier_sh[i] = TIER_SSD;
            n++;
         end
      return n;
   endfunction

   function automatic outcome_type place_step(op_type op);
      outcome_type o;
      logic [TierW-1:0] t, old;
      logic [BytesW-1:0] b, freed, nb;
      logic [53:0] need;
      bit shown;
      int r;
      o = '0;
      o.status = 1;
      shown = 0;
      r = 0;
      t = op.tier > TIER_SSD ? TIER_SSD : op.tier;
      if (op.kind == OP_REGISTER) begin
         if (nregions < MaxRegions) begin
            r = nregions;
            sz_sh[r] = op.size; tier_sh[r] = t; ld_sh[r] = 0; cnt_sh[r] = 0;
            if (t != TIER_SSD) begin
               b = share(op.size, t);
               if (54'(used_sh) + b > budget_sh) tier_sh[r] = TIER_SSD;
               else begin
                  ld_sh[r] = 1; cnt_sh[r] = 1; used_sh = used_sh + b;
               end
            end
            nregions++;
            o.index = IdxW'(r);
            o.status = 0;
            shown = 1;
         end
      end else if (op.kind == OP_TIER || op.kind == OP_ACCESS || op.kind == OP_EVICT) begin
         if (op.idx < nregions) begin
            r = op.idx;
            shown = 1;
            o.status = 0;
            if (op.kind == OP_TIER) begin
               old = tier_sh[r];
               if (old == t) begin
               end else if (old != TIER_SSD && t != TIER_SSD) begin
                  if (ld_sh[r])
                     used_sh = drop(used_sh, share(sz_sh[r], old)) + share(sz_sh[r], t);
                  tier_sh[r] = t;
               end else if (old == TIER_SSD) begin
                  freed = ld_sh[r] ? share(sz_sh[r], old) : '0;
                  nb = share(sz_sh[r], t);
                  // 54-bit wrap as in unsigned arithmetic; freed <= used here
                  need = 54'(used_sh) - freed + nb;
                  if (need > budget_sh) begin
                     o.evicted = CntW'(sweep_cold());
                     need = 54'(used_sh) - freed + nb;
                     if (need > budget_sh) o.status = 1;
                  end
                  if (o.status == 0) begin
                     used_sh = drop(used_sh, freed) + nb;
                     ld_sh[r] = 1;
                     if (cnt_sh[r] != '1) cnt_sh[r]++;
                     tier_sh[r] = t;
                  end
               end else begin
                  if (ld_sh[r]) used_sh = drop(used_sh, share(sz_sh[r], old));
                  ld_sh[r] = 0;
                  tier_sh[r] = TIER_SSD;
               end
            end else if (op.kind == OP_ACCESS) begin
               if (!ld_sh[r]) begin
                  used_sh = used_sh + share(sz_sh[r], tier_sh[r]);
                  ld_sh[r] = 1;
                  if (cnt_sh[r] != '1) cnt_sh[r]++;
               end
            end else begin
               if (ld_sh[r] || tier_sh[r] != TIER_SSD) o.evicted = 1;
               if (ld_sh[r]) used_sh = drop(used_sh, share(sz_sh[r], tier_sh[r]));
               ld_sh[r] = 0;
               tier_sh[r] = TIER_SSD;
            end
         end
      end else if (op.kind == OP_COLD) begin
         o.evicted = CntW'(sweep_cold());
         o.status = 0;
      end else if (op.kind == OP_TRIM) begin
         if (used_sh > budget_sh) o.evicted = CntW'(sweep_cold());
         o.status = 0;
      end
      if (shown) begin
         o.tier = tier_sh[r]; o.loaded = ld_sh[r]; o.loads = cnt_sh[r];
      end
      o.used = used_sh;
      o.avail = budget_sh > used_sh ? budget_sh - used_sh : '0;
      return o;
   endfunction

   task automatic set_budget(logic [BytesW-1:0] v);
      // idle, plus room for a walk still finishing
      repeat (40) @(posedge clock);
      csr_wr_en <= 1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 0;
      budget_sh = v;
   endtask

   task automatic send_op(op_type op, bit fixed, outcome_type want);
      outcome_type p;
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {5'b0, op.tier, op.size, op.idx, op.kind};
      do @(posedge clock); while (!req_tready);
      p = place_step(op);
      if (fixed && p != want)
         $display("%0t: table row disagrees with shadow: table %h shadow %h", $time, want, p);
      pending_outcomes.push_back(fixed ? want : p);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (pending_outcomes.size() != 0) @(posedge clock);
   endtask

   // response side
   always @(posedge clock) begin
      outcome_type a, e;
      if (rsp_tvalid && rsp_tready) begin
         a = rsp_tdata;
         got++;
         if (pending_outcomes.size() == 0) begin
            $display("%0t: unexpected response %h", $time, a);
            errors++;
         end else begin
            e = pending_outcomes.pop_front();
            if (a != e) begin
               errors++;
               $display("%0t: mismatch exp st%0d ix%0d t%0d l%0d n%0d u%0d a%0d ev%0d",
                        $time, e.status, e.index, e.tier, e.loaded, e.loads, e.used,
                        e.avail, e.evicted);
               $display("%0t:          act st%0d ix%0d t%0d l%0d n%0d u%0d a%0d ev%0d",
                        $time, a.status, a.index, a.tier, a.loaded, a.loads, a.used,
                        a.avail, a.evicted);
            end
         end
      end
      // random idle bursts, never back to back
      if (reset || hold_rsp) begin
         rsp_tready <= 0;
      end else if (rsp_gap > 0) begin
         rsp_tready <= 0;
         rsp_gap--;
      end else if (!calm && rsp_tready && $urandom_range(0, 4) == 0) begin
         rsp_tready <= 0;
         rsp_gap = $urandom_range(0, 2);
      end else begin
         rsp_tready <= 1;
      end
   end

   // long receiver hold-off so the block backs up its input
   task automatic stall_rsp();
      hold_rsp = 1;
      repeat (200) @(posedge clock);
      hold_rsp = 0;
   endtask

   int cycles = 0;
   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("tiered_weight_placement_budget_test: done, errors");
         $finish;
      end
   end

   function automatic op_type mk(logic [2:0] k, int i, logic [SizeW-1:0] s, logic [2:0] t);
      op_type o;
      o.kind = k; o.idx = IdxW'(i); o.size = s; o.tier = t;
      return o;
   endfunction

   function automatic outcome_type res(bit st, int u, int av);
      outcome_type o;
      o = '0; o.status = st; o.used = BytesW'(u); o.avail = BytesW'(av);
      return o;
   endfunction

   function automatic op_type random_op();
      op_type o;
      int k;
      k = $urandom_range(0, 99);
      o.size = $urandom_range(0, 3) == 0 ? SizeW'({$urandom, $urandom}) :
               SizeW'($urandom_range(0, 4095));
      o.tier = $urandom_range(0, 9) == 0 ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      o.idx = nregions > 0 && $urandom_range(0, 9) != 0 ?
              IdxW'($urandom_range(0, nregions - 1)) : IdxW'($urandom);
      if (k < 25) o.kind = OP_REGISTER;
      else if (k < 50) o.kind = OP_TIER;
      else if (k < 70) o.kind = OP_ACCESS;
      else if (k < 85) o.kind = OP_EVICT;
      else if (k < 90) o.kind = OP_COLD;
      else if (k < 97) o.kind = OP_TRIM;
      else o.kind = 3'($urandom_range(6, 7));
      if (o.kind == OP_REGISTER && nregions >= 400) o.kind = OP_ACCESS;
      return o;
   endfunction

   plan_row_type plan[$];

   initial begin
      outcome_type none;
      none = '0;
      budget_sh = '0; nregions = 0; used_sh = '0;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // budget zero: fixed rows straight after reset
      plan.push_back('{mk(OP_ACCESS, 0, 0, 0), 1, res(1, 0, 0)});
      plan.push_back('{mk(OP_TIER, 8191, 0, 0), 1, res(1, 0, 0)});
      plan.push_back('{mk(OP_EVICT, 3, 0, 0), 1, res(1, 0, 0)});
      plan.push_back('{mk(OP_COLD, 0, 0, 0), 1, res(0, 0, 0)});
      plan.push_back('{mk(OP_TRIM, 0, 0, 0), 1, res(0, 0, 0)});
      plan.push_back('{mk(3'd6, 0, 0, 0), 1, res(1, 0, 0)});
      plan.push_back('{mk(3'd7, 8191, '1, 7), 1, res(1, 0, 0)});
      foreach (plan[i]) send_op(plan[i].op, plan[i].fixed, plan[i].want);
      drain();
      plan.delete();

      set_budget(BUDGET_MAX);
      plan.push_back('{mk(OP_REGISTER, 0, '1, 0), 0, none});
      plan.push_back('{mk(OP_REGISTER, 0, 40'h12345, 1), 0, none});
      plan.push_back('{mk(OP_REGISTER, 0, 40'h800, 2), 0, none});
      plan.push_back('{mk(OP_REGISTER, 0, 40'h1000, 3), 0, none});
      plan.push_back('{mk(OP_REGISTER, 0, 40'h4000, 4), 0, none});
      plan.push_back('{mk(OP_REGISTER, 0, 40'h77, 6), 0, none});
      plan.push_back('{mk(OP_ACCESS, 4, 0, 0), 0, none});
      plan.push_back('{mk(OP_TIER, 1, 0, 3), 0, none});
      plan.push_back('{mk(OP_TIER, 0, 0, 4), 0, none});
      plan.push_back('{mk(OP_TIER, 0, 0, 2), 0, none});
      plan.push_back('{mk(OP_TIER, 2, 0, 2), 0, none});
      plan.push_back('{mk(OP_EVICT, 3, 0, 0), 0, none});
      plan.push_back('{mk(OP_EVICT, 3, 0, 0), 0, none});
      plan.push_back('{mk(OP_COLD, 0, 0, 0), 0, none});
      plan.push_back('{mk(OP_TRIM, 0, 0, 0), 0, none});
      foreach (plan[i]) send_op(plan[i].op, plan[i].fixed, plan[i].want);
      drain();

      // tight budget: drops to SSD, failed tier change after cold sweep, trim
      set_budget(52'd300);
      send_op(mk(OP_REGISTER, 0, 40'd4000, 0), 0, none);
      send_op(mk(OP_REGISTER, 0, 40'd1600, 2), 0, none);
      send_op(mk(OP_TIER, 0, 0, 0), 0, none);
      send_op(mk(OP_ACCESS, 8, 0, 0), 0, none);
      send_op(mk(OP_TRIM, 0, 0, 0), 0, none);
      drain();

      fork
         stall_rsp();
         for (int i = 0; i < 60; i++) send_op(random_op(), 0, none);
      join
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: set_budget(BytesW'($urandom_range(0, 20000)));
            1: set_budget(BUDGET_MAX);
            2: set_budget('0);
            default: set_budget(BytesW'($urandom_range(500, 200000)));
         endcase
         if (ph == 5) calm = 1;
         for (int i = 0; i < 310; i++) send_op(random_op(), 0, none);
         drain();
      end

      repeat (50) @(posedge clock);
      if (errors == 0 && pending_outcomes.size() == 0)
         $display("tiered_weight_placement_budget_test: done, clean");
      else
         $display("tiered_weight_placement_budget_test: done, errors");
      $finish;
   end
endmodule
